// ===== hw/rtl/dglcd_pkg.sv =====
`default_nettype none
package dglcd_pkg;

  localparam int COLUMNS    = 64;
  localparam int PAGES      = 8;
  localparam int HALF_CELLS = PAGES * COLUMNS;
  localparam int RAM_DEPTH  = 2 * HALF_CELLS;
  localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ADDR_W     = $clog2(RAM_DEPTH);

  localparam logic [1:0] MODE_CMD  = 2'd0;
  localparam logic [1:0] MODE_DWR  = 2'd1;
  localparam logic [1:0] MODE_STAT = 2'd2;
  localparam logic [1:0] MODE_DRD  = 2'd3;

  localparam logic [1:0] CS_LEFT  = 2'd1;
  localparam logic [1:0] CS_RIGHT = 2'd2;

  localparam logic [7:0] CMD_ONOFF  = 8'h3E;
  localparam logic [7:0] CMD_COLUMN = 8'h40;
  localparam logic [7:0] CMD_PAGE   = 8'hB8;
  localparam logic [7:0] CMD_START  = 8'hC0;
  localparam logic [7:0] MASK_ONOFF = 8'hFE;
  localparam logic [7:0] MASK_PAGE  = 8'hF8;
  localparam logic [7:0] MASK_TOP2  = 8'hC0;
  localparam logic [7:0] ST_BUSY    = 8'h80;
  localparam logic [7:0] ST_OFF     = 8'h20;
  localparam logic [7:0] ST_RESET   = 8'h10;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] chip_select;
    logic [7:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       left_on;
    logic       right_on;
    logic [5:0] left_start;
    logic [5:0] right_start;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic exec;
    logic latch_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic rd_item;
  } dp_stat_t;

  function automatic logic [COL_W-1:0] col_mod(input logic [5:0] v);
    logic [6:0] r;
    r = {1'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= 7'(COLUMNS)) r = r - 7'(COLUMNS);
    end
    return r[COL_W-1:0];
  endfunction

  function automatic logic [PAGE_W-1:0] page_mod(input logic [2:0] v);
    logic [3:0] r;
    r = {1'b0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= 4'(PAGES)) r = r - 4'(PAGES);
    end
    return r[PAGE_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dglcd_ram.sv =====
`default_nettype none
module dglcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dglcd_ctrl.sv =====
`default_nettype none
module dglcd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire dglcd_pkg::dp_stat_t stat,
  output logic                    busy,
  output dglcd_pkg::dp_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LATCH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (stat.clear_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (start && stat.rd_item) state_nxt = ST_LATCH;
      ST_LATCH: state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign cmd.clear      = (state_r == ST_CLEAR);
  assign cmd.exec       = (state_r == ST_IDLE) && start;
  assign cmd.latch_load = (state_r == ST_LATCH);

endmodule
`default_nettype wire

// ===== hw/rtl/dglcd_dp.sv =====
`default_nettype none
module dglcd_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dglcd_pkg::dp_cmd_t  cmd,
  input  wire dglcd_pkg::in_item_t in_item,
  output dglcd_pkg::dp_stat_t      stat,
  output logic                     out_strobe,
  output dglcd_pkg::out_item_t     out_item
);

  localparam int AW = dglcd_pkg::ADDR_W;
  localparam int CW = dglcd_pkg::COL_W;
  localparam int PW = dglcd_pkg::PAGE_W;

  logic [CW-1:0] col_r   [2];
  logic [CW-1:0] col_nxt [2];
  logic [PW-1:0] page_r  [2];
  logic [PW-1:0] page_nxt[2];
  logic [5:0]    start_r  [2];
  logic [5:0]    start_nxt[2];
  logic          on_r  [2];
  logic          on_nxt[2];
  logic [7:0]    latch_r  [2];
  logic [7:0]    latch_nxt[2];
  logic          lat_half_r, lat_half_nxt;
  logic [AW-1:0] clr_addr_r;
  logic          out_strobe_r;
  dglcd_pkg::out_item_t out_r, out_nxt;

  logic          half;
  logic          sel;
  logic [AW-1:0] cell_addr;
  logic [CW-1:0] col_adv;
  logic [7:0]    rd;
  logic [7:0]    d;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  assign d    = in_item.data_in;
  assign half = (in_item.chip_select == dglcd_pkg::CS_RIGHT);
  assign sel  = (in_item.chip_select == dglcd_pkg::CS_LEFT) ||
                (in_item.chip_select == dglcd_pkg::CS_RIGHT);
  assign cell_addr = AW'(AW'(half) * AW'(dglcd_pkg::HALF_CELLS)
                     + AW'(page_r[half]) * AW'(dglcd_pkg::COLUMNS)
                     + AW'(col_r[half]));
  assign col_adv = (col_r[half] == CW'(dglcd_pkg::COLUMNS - 1)) ? '0 : col_r[half] + 1'b1;

  assign stat.clear_last = (clr_addr_r == AW'(dglcd_pkg::RAM_DEPTH - 1));
  assign stat.rd_item    = sel && (in_item.mode == dglcd_pkg::MODE_DRD);

  always_comb begin
    col_nxt      = col_r;
    page_nxt     = page_r;
    start_nxt    = start_r;
    on_nxt       = on_r;
    latch_nxt    = latch_r;
    lat_half_nxt = lat_half_r;
    rd           = '0;
    ram_we       = 1'b0;
    ram_waddr    = cell_addr;
    ram_wdata    = d;

    if (cmd.latch_load) latch_nxt[lat_half_r] = ram_rdata;

    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (cmd.exec && sel) begin
      case (in_item.mode)
        dglcd_pkg::MODE_CMD: begin
          if ((d & dglcd_pkg::MASK_ONOFF) == dglcd_pkg::CMD_ONOFF) begin
            on_nxt[half] = d[0];
          end else if ((d & dglcd_pkg::MASK_TOP2) == dglcd_pkg::CMD_COLUMN) begin
            col_nxt[half] = dglcd_pkg::col_mod(d[5:0]);
          end else if ((d & dglcd_pkg::MASK_PAGE) == dglcd_pkg::CMD_PAGE) begin
            page_nxt[half] = dglcd_pkg::page_mod(d[2:0]);
          end else if ((d & dglcd_pkg::MASK_TOP2) == dglcd_pkg::CMD_START) begin
            start_nxt[half] = d[5:0];
          end
        end
        dglcd_pkg::MODE_DWR: begin
          ram_we        = 1'b1;
          col_nxt[half] = col_adv;
        end
        dglcd_pkg::MODE_STAT: begin
          rd = on_r[half] ? 8'h00 : dglcd_pkg::ST_OFF;
          rd = rd & ~(dglcd_pkg::ST_BUSY | dglcd_pkg::ST_RESET);
        end
        default: begin
          rd            = latch_r[half];
          lat_half_nxt  = half;
          col_nxt[half] = col_adv;
        end
      endcase
    end

    out_nxt.read_data   = rd;
    out_nxt.left_on     = on_nxt[0];
    out_nxt.right_on    = on_nxt[1];
    out_nxt.left_start  = start_nxt[0];
    out_nxt.right_start = start_nxt[1];
  end

  dglcd_ram #(
    .WIDTH(8),
    .DEPTH(dglcd_pkg::RAM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.exec),
    .raddr(cell_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int h = 0; h < 2; h++) begin
        col_r[h]   <= '0;
        page_r[h]  <= '0;
        start_r[h] <= '0;
        on_r[h]    <= 1'b0;
        latch_r[h] <= '0;
      end
      lat_half_r   <= 1'b0;
      clr_addr_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      col_r        <= col_nxt;
      page_r       <= page_nxt;
      start_r      <= start_nxt;
      on_r         <= on_nxt;
      latch_r      <= latch_nxt;
      lat_half_r   <= lat_half_nxt;
      if (cmd.clear) clr_addr_r <= clr_addr_r + 1'b1;
      out_strobe_r <= cmd.exec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule
`default_nettype wire

// ===== hw/rtl/dual_glcd_page_column_controller.sv =====
// Channel | Signals                    | Transaction
// input   | start, busy, in_item       | start high while busy low
// result  | out_strobe, out_item       | out_strobe high for one cycle
//
// A result is registered and appears in the cycle after its input transaction.
// Data reads also pass through the ST_LATCH state (latch reload from the RAM
// registered read port) with busy high; all other accesses leave busy low.
// After reset the display RAM is cleared one byte a cycle: busy stays high
// until all 1024 bytes (2 * PAGES * COLUMNS) are cleared.
// The receiver cannot stall; results are never held.
`default_nettype none
module dual_glcd_page_column_controller (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire dglcd_pkg::in_item_t in_item,
  output logic                     out_strobe,
  output dglcd_pkg::out_item_t     out_item
);

  dglcd_pkg::dp_cmd_t  cmd;
  dglcd_pkg::dp_stat_t stat;

  dglcd_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  dglcd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .stat      (stat),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/dglcd_checker.sv =====
`default_nettype none
module dglcd_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 start,
  input wire logic                 busy,
  input wire dglcd_pkg::in_item_t  in_item,
  input wire logic                 out_strobe,
  input wire dglcd_pkg::out_item_t out_item
);

  logic acc;
  logic sel;

  assign acc = start && !busy;
  assign sel = (in_item.chip_select == dglcd_pkg::CS_LEFT) ||
               (in_item.chip_select == dglcd_pkg::CS_RIGHT);

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(acc && rst_n))
    else $error("result strobe without a preceding transaction");

  a_read_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && sel && in_item.mode == dglcd_pkg::MODE_DRD) |=> (busy && out_strobe))
    else $error("data read did not hold off the next transaction");

  a_status_bits: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_item.mode == dglcd_pkg::MODE_STAT)
      |=> ((out_item.read_data & ~dglcd_pkg::ST_OFF) == 8'h00))
    else $error("status read shows bits other than display off");

  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && (in_item.mode == dglcd_pkg::MODE_CMD || in_item.mode == dglcd_pkg::MODE_DWR))
      |=> (out_item.read_data == 8'h00))
    else $error("write returned nonzero read data");

  a_left_on: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_item.mode == dglcd_pkg::MODE_CMD && in_item.chip_select == dglcd_pkg::CS_LEFT
      && in_item.data_in == (dglcd_pkg::CMD_ONOFF | 8'h01)) |=> out_item.left_on)
    else $error("display on command did not enable the left half");

endmodule

bind dual_glcd_page_column_controller dglcd_checker u_dglcd_checker (.*);
`default_nettype wire
